>>> hw/rtl/rot_pkg.sv
// Shared types, widths and codes of the reference-counting object table.
package rot_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 32;
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 31;
  localparam int CNT_W   = 16;
  localparam int ENTRY_W = ADDR_W + SIZE_W + CNT_W;

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_INC    = 3'd3,
    OP_DEC    = 3'd4,
    OP_SWEEP  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_FULL       = 2'd2,
    ST_NONE_FREED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic finish_en;
    op_t  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit_stop;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/rot_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/rot_ctrl.sv
// Controller state machine: accepts words and sequences the slot walk.
module rot_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  rot_pkg::dp_status_t st,
  output rot_pkg::ctrl_cmd_t  cmd
);

  rot_pkg::state_t state_r, state_nxt;
  rot_pkg::op_t    op_r, op_nxt;
  logic            legal;

  always_comb begin
    unique case (rot_pkg::op_t'(in_operation))
      rot_pkg::OP_INSERT, rot_pkg::OP_DELETE, rot_pkg::OP_LOOKUP,
      rot_pkg::OP_INC, rot_pkg::OP_DEC, rot_pkg::OP_SWEEP: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      rot_pkg::S_IDLE: begin
        if (in_valid && legal) begin
          state_nxt = rot_pkg::S_SCAN;
          op_nxt    = rot_pkg::op_t'(in_operation);
        end
      end
      rot_pkg::S_SCAN: begin
        if (st.hit_stop || st.scan_done) begin
          state_nxt = rot_pkg::S_FINISH;
        end
      end
      rot_pkg::S_FINISH: begin
        if (st.out_free) begin
          state_nxt = rot_pkg::S_IDLE;
        end
      end
      default: state_nxt = rot_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.start     = 1'b0;
    cmd.scan_en   = 1'b0;
    cmd.finish_en = 1'b0;
    cmd.op        = op_r;
    unique case (state_r)
      rot_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid && legal;
      end
      rot_pkg::S_SCAN:   cmd.scan_en   = 1'b1;
      rot_pkg::S_FINISH: cmd.finish_en = st.out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rot_pkg::S_IDLE;
      op_r    <= rot_pkg::OP_INSERT;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

>>> hw/rtl/rot_datapath.sv
// Datapath: slot storage, valid bits, slot walk, compare and result register.
module rot_datapath #(
  parameter int TABLE_DEPTH = rot_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rot_pkg::ctrl_cmd_t                cmd,
  output rot_pkg::dp_status_t               st,
  input  logic [rot_pkg::ADDR_W-1:0]        in_obj_addr,
  input  logic [rot_pkg::SIZE_W-1:0]        in_obj_size,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [rot_pkg::ADDR_W-1:0]        out_addr,
  output logic [rot_pkg::SIZE_W-1:0]        out_size,
  output logic signed [rot_pkg::CNT_W-1:0]  out_ref_count,
  output logic                              out_last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int AW = rot_pkg::ADDR_W;
  localparam int SW = rot_pkg::SIZE_W;
  localparam int CW = rot_pkg::CNT_W;

  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [PTR_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   c_vld_r, c_vld_nxt;
  logic [IDX_W-1:0]       c_idx_r, c_idx_nxt;
  logic [AW-1:0]          key_r, key_nxt;
  logic [SW-1:0]          size_r, size_nxt;
  logic                   hit_r, hit_nxt;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  logic [AW-1:0]          hit_addr_r, hit_addr_nxt;
  logic [SW-1:0]          hit_size_r, hit_size_nxt;
  logic signed [CW-1:0]   hit_cnt_r, hit_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  rot_pkg::status_t       out_status_r, out_status_nxt;
  logic [AW-1:0]          out_addr_r, out_addr_nxt;
  logic [SW-1:0]          out_size_r, out_size_nxt;
  logic signed [CW-1:0]   out_cnt_r, out_cnt_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                       ram_we, ram_re;
  logic [IDX_W-1:0]           ram_waddr;
  logic [rot_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [AW-1:0]        q_addr;
  logic [SW-1:0]        q_size;
  logic signed [CW-1:0] q_cnt;
  logic                 vbit, hit_cond, hit_now, single_op, pause, adv, out_free;
  logic signed [CW-1:0] new_cnt;

  rot_ram #(
    .WIDTH (rot_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign q_addr = ram_rdata[rot_pkg::ENTRY_W-1 -: AW];
  assign q_size = ram_rdata[CW +: SW];
  assign q_cnt  = signed'(ram_rdata[CW-1:0]);
  assign vbit   = valid_r[c_idx_r];

  always_comb begin
    hit_cond  = 1'b0;
    single_op = 1'b0;
    unique case (cmd.op)
      rot_pkg::OP_INSERT: begin
        hit_cond  = !vbit;
        single_op = 1'b1;
      end
      rot_pkg::OP_DELETE: hit_cond = vbit && (q_addr == key_r);
      rot_pkg::OP_LOOKUP, rot_pkg::OP_INC, rot_pkg::OP_DEC: begin
        hit_cond  = vbit && (q_addr == key_r);
        single_op = 1'b1;
      end
      rot_pkg::OP_SWEEP: hit_cond = vbit && (q_cnt == '0);
      default: hit_cond = 1'b0;
    endcase
  end

  always_comb begin
    new_cnt = hit_cnt_r;
    if (cmd.op == rot_pkg::OP_INC && hit_cnt_r != rot_pkg::CNT_MAX) begin
      new_cnt = hit_cnt_r + CW'(1);
    end else if (cmd.op == rot_pkg::OP_DEC && hit_cnt_r != rot_pkg::CNT_MIN) begin
      new_cnt = hit_cnt_r - CW'(1);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign hit_now  = c_vld_r && hit_cond;
  assign pause    = (cmd.op == rot_pkg::OP_SWEEP) && hit_now && hit_r && !out_free;
  assign adv      = cmd.scan_en && !pause;

  assign st.hit_stop  = cmd.scan_en && hit_now && single_op;
  assign st.scan_done = (rd_idx_r == PTR_W'(TABLE_DEPTH)) && !c_vld_r;
  assign st.out_free  = out_free;

  always_comb begin
    valid_nxt      = valid_r;
    rd_idx_nxt     = rd_idx_r;
    c_vld_nxt      = c_vld_r;
    c_idx_nxt      = c_idx_r;
    key_nxt        = key_r;
    size_nxt       = size_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_addr_nxt   = hit_addr_r;
    hit_size_nxt   = hit_size_r;
    hit_cnt_nxt    = hit_cnt_r;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    ram_wdata      = {hit_addr_r, hit_size_r, new_cnt};
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_size_nxt   = out_size_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;

    if (cmd.start) begin
      rd_idx_nxt = '0;
      c_vld_nxt  = 1'b0;
      hit_nxt    = 1'b0;
      key_nxt    = in_obj_addr;
      size_nxt   = in_obj_size;
    end else if (adv) begin
      if (rd_idx_r != PTR_W'(TABLE_DEPTH)) begin
        ram_re     = 1'b1;
        c_vld_nxt  = 1'b1;
        c_idx_nxt  = rd_idx_r[IDX_W-1:0];
        rd_idx_nxt = rd_idx_r + PTR_W'(1);
      end else begin
        c_vld_nxt = 1'b0;
      end
      if (hit_now) begin
        if (cmd.op == rot_pkg::OP_SWEEP && hit_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rot_pkg::ST_OK;
          out_addr_nxt   = hit_addr_r;
          out_size_nxt   = hit_size_r;
          out_cnt_nxt    = '0;
          out_last_nxt   = 1'b0;
        end
        if (cmd.op == rot_pkg::OP_SWEEP || cmd.op == rot_pkg::OP_DELETE) begin
          valid_nxt[c_idx_r] = 1'b0;
        end
        if (!hit_r || cmd.op == rot_pkg::OP_SWEEP) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = c_idx_r;
          hit_addr_nxt = q_addr;
          hit_size_nxt = q_size;
          hit_cnt_nxt  = q_cnt;
        end
      end
    end else if (cmd.finish_en) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      out_status_nxt = rot_pkg::ST_OK;
      out_addr_nxt   = hit_addr_r;
      out_size_nxt   = hit_size_r;
      out_cnt_nxt    = hit_cnt_r;
      unique case (cmd.op)
        rot_pkg::OP_INSERT: begin
          out_addr_nxt = key_r;
          out_size_nxt = size_r;
          out_cnt_nxt  = '0;
          ram_wdata    = {key_r, size_r, {CW{1'b0}}};
          if (hit_r) begin
            valid_nxt[hit_idx_r] = 1'b1;
            ram_we               = 1'b1;
          end else begin
            out_status_nxt = rot_pkg::ST_FULL;
          end
        end
        rot_pkg::OP_DELETE, rot_pkg::OP_LOOKUP: begin
          if (!hit_r) begin
            out_status_nxt = rot_pkg::ST_NOT_FOUND;
          end
        end
        rot_pkg::OP_INC, rot_pkg::OP_DEC: begin
          out_cnt_nxt = new_cnt;
          if (hit_r) begin
            ram_we = 1'b1;
          end else begin
            out_status_nxt = rot_pkg::ST_NOT_FOUND;
          end
        end
        rot_pkg::OP_SWEEP: begin
          out_cnt_nxt = '0;
          if (!hit_r) begin
            out_status_nxt = rot_pkg::ST_NONE_FREED;
          end
        end
        default: out_valid_nxt = 1'b0;
      endcase
      if (!hit_r) begin
        out_addr_nxt = '0;
        out_size_nxt = '0;
        out_cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rd_idx_r    <= '0;
      c_vld_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      c_vld_r     <= c_vld_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_idx_r      <= c_idx_nxt;
    key_r        <= key_nxt;
    size_r       <= size_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_addr_r   <= hit_addr_nxt;
    hit_size_r   <= hit_size_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_size_r   <= out_size_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_addr      = out_addr_r;
  assign out_size      = out_size_r;
  assign out_ref_count = out_cnt_r;
  assign out_last      = out_last_r;

endmodule

>>> hw/rtl/refcount_object_table_top.sv
// Timing: a word walks the slots one per cycle through the table RAM read port, pausing while a
// sweep result waits on a stalled output; a finish step then registers its last result word.
// The walk ends early on a hit for insert, lookup, increment and decrement.
// Throughput: one word at a time, as in_stall is held while a word is in progress, and a sweep
// delivers up to TABLE_DEPTH result words.
// Reset: synchronous and active low; all slots become free at once, with no clearing pass.
module refcount_object_table_top #(
  parameter int TABLE_DEPTH = rot_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_operation,
  input  logic [rot_pkg::ADDR_W-1:0]        in_obj_addr,
  input  logic [rot_pkg::SIZE_W-1:0]        in_obj_size,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [rot_pkg::ADDR_W-1:0]        out_addr,
  output logic [rot_pkg::SIZE_W-1:0]        out_size,
  output logic signed [rot_pkg::CNT_W-1:0]  out_ref_count,
  output logic                              out_last
);

  rot_pkg::ctrl_cmd_t  cmd;
  rot_pkg::dp_status_t st;

  rot_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .st           (st),
    .cmd          (cmd)
  );

  rot_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_obj_addr   (in_obj_addr),
    .in_obj_size   (in_obj_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_addr      (out_addr),
    .out_size      (out_size),
    .out_ref_count (out_ref_count),
    .out_last      (out_last)
  );

endmodule
